>>> rtl/cosine_similarity_dense_unit_defines.svh
// Assertion helpers used by csd_ctrl.sv
`ifndef COSINE_SIMILARITY_DENSE_UNIT_DEFINES_SVH
`define COSINE_SIMILARITY_DENSE_UNIT_DEFINES_SVH

// Same-cycle implication
`define CSD_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define CSD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/csd_pkg.sv
package csd_pkg;

    localparam int ELEM_W    = 16;
    localparam int DOT_W     = 48;
    localparam int NORM_W    = 47;
    localparam int HALF_W    = 24;
    localparam int PROD_W    = 96;
    localparam int ROOT_W    = PROD_W / 2;
    localparam int DIVD_W    = DOT_W + 15;
    localparam int CNT_W     = 6;
    localparam int ADDR_W    = 4;
    localparam int DATA_W    = 64;
    localparam int MUL_STEPS = 4;

    localparam logic REG_MODE   = 1'b0;
    localparam logic REG_A_NORM = 1'b1;

    typedef struct packed {
        logic       accum;
        logic       capture;
        logic       mul;
        logic [1:0] mul_sel;
        logic       sqrt;
        logic       div;
        logic       load_out;
    } csd_cmd_t;

    typedef struct packed {
        logic zero;
    } csd_stat_t;

endpackage

>>> rtl/cosine_similarity_dense_unit.sv
// Streaming cosine similarity. Element pairs are accepted one per cycle while the
// block accumulates; the pair flagged last starts the finishing sequence, during
// which no further items are taken: 24x24 partial products for the product of
// the norms, a two-bits-per-step square root and a restoring divider, then the
// load of the result register, which waits while a previous result is still
// untaken. A zero norm skips the arithmetic and returns 0 with status 1.
module cosine_similarity_dense_unit (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [csd_pkg::ADDR_W-1:0] paddr,
    input  logic [csd_pkg::DATA_W-1:0] pwdata,
    output logic [csd_pkg::DATA_W-1:0] prdata,
    output logic                      pready,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic [15:0]               a_elem,
    input  logic [15:0]               b_elem,
    input  logic                      last,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic [15:0]               similarity,
    output logic                      status
);
    import csd_pkg::*;

    logic              mode_reg;
    logic [NORM_W-1:0] a_norm_reg;
    logic              wr_en;
    csd_cmd_t          cmd;
    csd_stat_t         stat;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= 1'b0;
            a_norm_reg <= '0;
        end
        else if (wr_en)
        begin
            unique case (paddr[3])
                REG_MODE:   mode_reg   <= pwdata[0];
                REG_A_NORM: a_norm_reg <= pwdata[NORM_W-1:0];
                default:    ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3])
            REG_MODE:   prdata = DATA_W'(mode_reg);
            REG_A_NORM: prdata = DATA_W'(a_norm_reg);
            default:    prdata = '0;
        endcase
    end

    csd_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_last   (last),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    csd_datapath u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .a_elem     (a_elem),
        .b_elem     (b_elem),
        .mode       (mode_reg),
        .a_norm_sq  (a_norm_reg),
        .cmd        (cmd),
        .stat       (stat),
        .similarity (similarity),
        .status     (status)
    );

endmodule

>>> rtl/csd_datapath.sv
module csd_datapath (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic [15:0]               a_elem,
    input  logic [15:0]               b_elem,
    input  logic                      mode,
    input  logic [csd_pkg::NORM_W-1:0] a_norm_sq,
    input  csd_pkg::csd_cmd_t         cmd,
    output csd_pkg::csd_stat_t        stat,
    output logic [15:0]               similarity,
    output logic                      status
);
    import csd_pkg::*;

    logic signed [ELEM_W-1:0]   a_s, b_s;
    logic signed [2*ELEM_W-1:0] ab, aa, bb;
    logic signed [DOT_W:0]      dot_sum;
    logic [NORM_W:0]            an_sum, bn_sum;
    logic signed [DOT_W-1:0]    dot_next;
    logic [NORM_W-1:0]          an_next, bn_next;

    logic signed [DOT_W-1:0] dot_reg;
    logic [NORM_W-1:0]       an_reg, bn_reg;
    logic [NORM_W-1:0]       a2_reg, b2_reg;
    logic                    neg_reg;
    logic [PROD_W-1:0]       p_reg;
    logic [ROOT_W:0]         rem_reg;
    logic [ROOT_W-1:0]       root_reg;
    logic [DOT_W-1:0]        drem_reg;
    logic [DIVD_W-1:0]       divd_reg;
    logic [DIVD_W-1:0]       q_reg;
    logic [15:0]             similarity_reg;
    logic                    status_reg;

    logic [DOT_W-1:0]        mag;
    logic [HALF_W-1:0]       mul_x, mul_y;
    logic [2*HALF_W-1:0]     pp;
    logic [PROD_W-1:0]       pp_sh;
    logic [ROOT_W+2:0]       rem_t, trial, rem_d;
    logic [DOT_W:0]          dr_t, dr_d;
    logic [15:0]             sim_next;

    assign a_s = a_elem[ELEM_W-1:0];
    assign b_s = b_elem[ELEM_W-1:0];
    assign ab  = a_s * b_s;
    assign aa  = a_s * a_s;
    assign bb  = b_s * b_s;

    always_comb
    begin
        dot_sum = {dot_reg[DOT_W-1], dot_reg} + (DOT_W+1)'(ab);
        if (dot_sum[DOT_W] != dot_sum[DOT_W-1])
            dot_next = dot_sum[DOT_W] ? {1'b1, {(DOT_W-1){1'b0}}} : {1'b0, {(DOT_W-1){1'b1}}};
        else
            dot_next = dot_sum[DOT_W-1:0];
        an_sum  = {1'b0, an_reg} + (NORM_W+1)'(unsigned'(aa));
        bn_sum  = {1'b0, bn_reg} + (NORM_W+1)'(unsigned'(bb));
        an_next = an_sum[NORM_W] ? {NORM_W{1'b1}} : an_sum[NORM_W-1:0];
        bn_next = bn_sum[NORM_W] ? {NORM_W{1'b1}} : bn_sum[NORM_W-1:0];
        mag     = dot_next[DOT_W-1] ? DOT_W'(-dot_next) : DOT_W'(dot_next);
    end

    // partial products of a2*b2, one per step
    always_comb
    begin
        mul_x = cmd.mul_sel[0] ? HALF_W'(a2_reg[NORM_W-1:HALF_W]) : a2_reg[HALF_W-1:0];
        mul_y = cmd.mul_sel[1] ? HALF_W'(b2_reg[NORM_W-1:HALF_W]) : b2_reg[HALF_W-1:0];
        pp    = mul_x * mul_y;
        case (cmd.mul_sel)
            2'b00:   pp_sh = PROD_W'(pp);
            2'b11:   pp_sh = PROD_W'(pp) << (2*HALF_W);
            default: pp_sh = PROD_W'(pp) << HALF_W;
        endcase
    end

    always_comb
    begin
        rem_t = {rem_reg, p_reg[PROD_W-1 -: 2]};
        trial = {1'b0, root_reg, 2'b01};
        rem_d = rem_t - trial;
        dr_t  = {drem_reg, divd_reg[DIVD_W-1]};
        dr_d  = dr_t - {1'b0, root_reg};
    end

    always_comb
    begin
        if (a2_reg == '0 || b2_reg == '0)
            sim_next = '0;
        else if (neg_reg)
            sim_next = (q_reg > DIVD_W'(32768)) ? 16'h8000 : 16'(-q_reg[15:0]);
        else
            sim_next = (q_reg > DIVD_W'(32767)) ? 16'h7fff : q_reg[15:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dot_reg <= '0;
            an_reg  <= '0;
            bn_reg  <= '0;
        end
        else if (cmd.capture)
        begin
            dot_reg <= '0;
            an_reg  <= '0;
            bn_reg  <= '0;
        end
        else if (cmd.accum)
        begin
            dot_reg <= dot_next;
            an_reg  <= an_next;
            bn_reg  <= bn_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            a2_reg   <= mode ? a_norm_sq : an_next;
            b2_reg   <= bn_next;
            neg_reg  <= dot_next[DOT_W-1];
            p_reg    <= '0;
            rem_reg  <= '0;
            root_reg <= '0;
            drem_reg <= '0;
            divd_reg <= {mag, 15'b0};
            q_reg    <= '0;
        end
        if (cmd.mul)
            p_reg <= p_reg + pp_sh;
        if (cmd.sqrt)
        begin
            p_reg <= p_reg << 2;
            if (!rem_d[ROOT_W+2])
            begin
                rem_reg  <= rem_d[ROOT_W:0];
                root_reg <= {root_reg[ROOT_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg  <= rem_t[ROOT_W:0];
                root_reg <= {root_reg[ROOT_W-2:0], 1'b0};
            end
        end
        if (cmd.div)
        begin
            divd_reg <= divd_reg << 1;
            if (!dr_d[DOT_W])
            begin
                drem_reg <= dr_d[DOT_W-1:0];
                q_reg    <= {q_reg[DIVD_W-2:0], 1'b1};
            end
            else
            begin
                drem_reg <= dr_t[DOT_W-1:0];
                q_reg    <= {q_reg[DIVD_W-2:0], 1'b0};
            end
        end
        if (cmd.load_out)
        begin
            similarity_reg <= sim_next;
            status_reg     <= (a2_reg == '0 || b2_reg == '0);
        end
    end

    assign stat.zero  = (a2_reg == '0 || b2_reg == '0);
    assign similarity = similarity_reg;
    assign status     = status_reg;

endmodule

>>> rtl/csd_ctrl.sv
`include "cosine_similarity_dense_unit_defines.svh"

module csd_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_last,
    output logic               in_ready,
    output logic               out_valid,
    input  logic               out_ready,
    input  csd_pkg::csd_stat_t stat,
    output csd_pkg::csd_cmd_t  cmd
);
    import csd_pkg::*;

    typedef enum logic [2:0] {ST_ACC, ST_MUL, ST_SQRT, ST_DIV, ST_OUT} state_t;

    state_t           state_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             out_valid_reg;
    logic             in_fire;

    assign in_ready = (state_reg == ST_ACC);
    assign in_fire  = in_valid && in_ready;

    always_comb
    begin
        cmd.accum    = in_fire;
        cmd.capture  = in_fire && in_last;
        cmd.mul      = (state_reg == ST_MUL);
        cmd.mul_sel  = cnt_reg[1:0];
        cmd.sqrt     = (state_reg == ST_SQRT);
        cmd.div      = (state_reg == ST_DIV);
        cmd.load_out = (state_reg == ST_OUT) && (!out_valid_reg || out_ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_ACC;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.load_out)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
            unique case (state_reg)
                ST_ACC:
                begin
                    cnt_reg <= '0;
                    if (cmd.capture)
                        state_reg <= ST_MUL;
                end
                ST_MUL:
                begin
                    if (stat.zero)
                        state_reg <= ST_OUT;
                    else if (cnt_reg == CNT_W'(MUL_STEPS-1))
                    begin
                        state_reg <= ST_SQRT;
                        cnt_reg   <= '0;
                    end
                    else
                        cnt_reg <= cnt_reg + 1'b1;
                end
                ST_SQRT:
                begin
                    if (cnt_reg == CNT_W'(ROOT_W-1))
                    begin
                        state_reg <= ST_DIV;
                        cnt_reg   <= '0;
                    end
                    else
                        cnt_reg <= cnt_reg + 1'b1;
                end
                ST_DIV:
                begin
                    if (cnt_reg == CNT_W'(DIVD_W-1))
                        state_reg <= ST_OUT;
                    else
                        cnt_reg <= cnt_reg + 1'b1;
                end
                ST_OUT:
                begin
                    if (cmd.load_out)
                        state_reg <= ST_ACC;
                end
                default: state_reg <= ST_ACC;
            endcase
        end
    end

    assign out_valid = out_valid_reg;

    // a last item stops intake until its result is loaded
    `CSD_ASSERT_NEXT(a_last_blocks, in_fire && in_last, !in_ready, "intake not stopped after last item")
    // hold the finished result while the previous one waits
    `CSD_ASSERT_NEXT(a_out_hold, state_reg == ST_OUT && out_valid_reg && !out_ready, state_reg == ST_OUT, "result loaded over a waiting one")
    `CSD_ASSERT_IMPL(a_mul_cnt, state_reg == ST_MUL, cnt_reg < CNT_W'(MUL_STEPS), "multiply step out of range")

endmodule
